// ===== sv/spq_pkg.sv =====
// Shared types, widths and codes for the sorted priority queue.
// No dependencies; every other file refers to it by scoped names.
package spq_pkg;

	// parameter defaults
	localparam int CAPACITY_DEF = 16;
	localparam int TAG_BITS_DEF = 16;

	// fixed field widths
	localparam int TAG_W    = 16;
	localparam int PRI_W    = 32;
	localparam int STATUS_W = 2;
	localparam int OCC_W    = 5;

	// slave tdata: item_tag, priority_req
	localparam int S_TDATA_W = TAG_W + PRI_W;

	// master tdata layout, lowest bit up
	localparam int O_STATUS  = 0;
	localparam int O_REMOVED = O_STATUS + STATUS_W;
	localparam int O_FTAG    = O_REMOVED + TAG_W;
	localparam int O_FPRI    = O_FTAG + TAG_W;
	localparam int O_OCC     = O_FPRI + PRI_W;
	localparam int O_EMPTY   = O_OCC + OCC_W;
	localparam int M_TDATA_W = O_EMPTY + 1;

	// operation kinds (tuser)
	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_REMOVE = 1'b1;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
	localparam logic [STATUS_W-1:0] ST_BAD   = 2'd3;

	// controller -> datapath
	typedef struct packed {
		logic load_in;   // capture input beat, reset result fields
		logic set_full;
		logic set_empty;
		logic rd_prev;   // read entry just ahead of the insert slot
		logic shift_wr;  // move read entry back one slot
		logic ins_wr;    // write new entry at insert slot
		logic rd_front;  // read entry at head
		logic pop;       // drop head entry
		logic out_load;  // load result register
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_remove;
		logic full;
		logic cnt_zero;
		logic pos_zero;
		logic greater;
		logic out_free;
	} sts_t;

endpackage

// ===== sv/sorted_priority_queue.sv =====
// Sorted priority queue: top level joining the sequencer and the datapath.
// Depends on spq_pkg, spq_ctrl, spq_dp.
//
// Holds up to CAPACITY tagged entries in descending priority order; equal
// priorities leave in arrival order. Each input beat (tuser 0 insert, 1 remove)
// yields one result beat with status, removed tag, front tag/priority,
// occupancy and empty flag. One item is processed at a time. An insert
// moves each stored entry of lower priority back one slot before it writes
// the new entry; each move is a read and then a write of the entry memory.
// A result waiting on m_tready does not block the next input beat from being
// accepted. No clearing pass is needed after reset.
module sorted_priority_queue #(
	parameter int CAPACITY = spq_pkg::CAPACITY_DEF,
	parameter int TAG_BITS = spq_pkg::TAG_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [spq_pkg::S_TDATA_W-1:0] s_tdata,  // item_tag[15:0], priority_req[47:16]
	input  logic                          s_tuser,  // kind
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// status[1:0], removed_tag[17:2], front_tag[33:18], front_priority[65:34],
	// occupancy[70:66], is_empty[71]
	output logic [spq_pkg::M_TDATA_W-1:0] m_tdata
);

	spq_pkg::cmd_t cmd;
	spq_pkg::sts_t sts;

	spq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	spq_dp #(
		.CAPACITY (CAPACITY),
		.TAG_BITS (TAG_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cmd      (cmd),
		.sts      (sts)
	);

endmodule

// ===== sv/spq_ctrl.sv =====
// Sequencer for the sorted priority queue.
// Depends on spq_pkg (cmd_t, sts_t).
module spq_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  spq_pkg::sts_t sts,
	output spq_pkg::cmd_t cmd
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DECIDE = 3'd1;
	localparam logic [2:0] S_SCAN   = 3'd2;
	localparam logic [2:0] S_CMP    = 3'd3;
	localparam logic [2:0] S_POP    = 3'd4;
	localparam logic [2:0] S_RDF    = 3'd5;
	localparam logic [2:0] S_FIN    = 3'd6;

	logic [2:0] state_q, state_d;

	assign s_tready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.load_in = 1'b1;
					state_d     = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (sts.is_remove) begin
					if (sts.cnt_zero) begin
						cmd.set_empty = 1'b1;
						state_d       = S_FIN;
					end else begin
						cmd.rd_front = 1'b1;
						state_d      = S_POP;
					end
				end else if (sts.full) begin
					cmd.set_full = 1'b1;
					state_d      = S_RDF;
				end else begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (sts.pos_zero) begin
					cmd.ins_wr = 1'b1;
					state_d    = S_RDF;
				end else begin
					cmd.rd_prev = 1'b1;
					state_d     = S_CMP;
				end
			end
			S_CMP: begin
				if (sts.greater) begin
					cmd.shift_wr = 1'b1;
					state_d      = S_SCAN;
				end else begin
					cmd.ins_wr = 1'b1;
					state_d    = S_RDF;
				end
			end
			S_POP: begin
				cmd.pop = 1'b1;
				state_d = S_RDF;
			end
			S_RDF: begin
				cmd.rd_front = 1'b1;
				state_d      = S_FIN;
			end
			S_FIN: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== sv/spq_dp.sv =====
// Datapath: ring-buffer entry memory, head/count/slot registers, result register.
// Depends on spq_pkg (widths, codes, cmd_t, sts_t).
module spq_dp #(
	parameter int CAPACITY = spq_pkg::CAPACITY_DEF,
	parameter int TAG_BITS = spq_pkg::TAG_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [spq_pkg::S_TDATA_W-1:0]    s_tdata,
	input  logic                             s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [spq_pkg::M_TDATA_W-1:0]    m_tdata,
	input  spq_pkg::cmd_t                    cmd,
	output spq_pkg::sts_t                    sts
);

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int PRI_W = spq_pkg::PRI_W;
	localparam int ENT_W = PRI_W + TAG_BITS;
	localparam logic [IDX_W:0] CAP_X = (IDX_W + 1)'(CAPACITY);
	localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

	// entries stored as {priority, tag}, logical slot 0 at head_q
	logic [ENT_W-1:0] mem [CAPACITY];

	logic                          kind_q;
	logic [TAG_BITS-1:0]           tag_q;
	logic [PRI_W-1:0]              pri_q;
	logic [spq_pkg::STATUS_W-1:0]  status_q;
	logic [TAG_BITS-1:0]           removed_q;
	logic [IDX_W-1:0]              head_q;
	logic [CNT_W-1:0]              cnt_q;
	logic [CNT_W-1:0]              pos_q;
	logic [ENT_W-1:0]              rd_q;
	logic [spq_pkg::M_TDATA_W-1:0] out_q;
	logic                          m_valid_q;

	logic [CNT_W-1:0]              pos_m1;
	logic [IDX_W-1:0]              wr_addr, rd_addr, head_nx;
	logic                          cnt_zero;
	logic [spq_pkg::TAG_W-1:0]     front_tag;
	logic [PRI_W-1:0]              front_pri;

	function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] head,
			input logic [IDX_W-1:0] slot);
		logic [IDX_W:0] s;
		s = {1'b0, head} + {1'b0, slot};
		if (s >= CAP_X) begin
			s = s - CAP_X;
		end
		return s[IDX_W-1:0];
	endfunction

	assign pos_m1   = pos_q - CNT_W'(1);
	assign wr_addr  = phys(head_q, pos_q[IDX_W-1:0]);
	assign rd_addr  = cmd.rd_prev ? phys(head_q, pos_m1[IDX_W-1:0]) : head_q;
	assign head_nx  = (head_q == IDX_W'(CAPACITY - 1)) ? '0 : head_q + IDX_W'(1);
	assign cnt_zero = (cnt_q == '0);

	assign sts.is_remove = (kind_q == spq_pkg::KIND_REMOVE);
	assign sts.full      = (cnt_q == CAP_C);
	assign sts.cnt_zero  = cnt_zero;
	assign sts.pos_zero  = (pos_q == '0);
	assign sts.greater   = $signed(pri_q) > $signed(rd_q[ENT_W-1 -: PRI_W]);
	assign sts.out_free  = !m_valid_q || m_tready;

	// memory: one write and one registered read port
	always_ff @(posedge clk) begin
		if (cmd.shift_wr) begin
			mem[wr_addr] <= rd_q;
		end else if (cmd.ins_wr) begin
			mem[wr_addr] <= {pri_q, tag_q};
		end
		if (cmd.rd_prev || cmd.rd_front) begin
			rd_q <= mem[rd_addr];
		end
	end

	// input beat and result fields
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			kind_q    <= s_tuser;
			tag_q     <= TAG_BITS'(s_tdata[spq_pkg::TAG_W-1:0]);
			pri_q     <= s_tdata[spq_pkg::S_TDATA_W-1 -: PRI_W];
			status_q  <= spq_pkg::ST_OK;
			removed_q <= '0;
		end else begin
			if (cmd.set_full) begin
				status_q <= spq_pkg::ST_FULL;
			end
			if (cmd.set_empty) begin
				status_q <= spq_pkg::ST_EMPTY;
			end
			if (cmd.pop) begin
				removed_q <= rd_q[TAG_BITS-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			cnt_q  <= '0;
			pos_q  <= '0;
		end else begin
			if (cmd.load_in) begin
				pos_q <= cnt_q;
			end else if (cmd.shift_wr) begin
				pos_q <= pos_m1;
			end
			if (cmd.ins_wr) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (cmd.pop) begin
				cnt_q  <= cnt_q - CNT_W'(1);
				head_q <= head_nx;
			end
		end
	end

	// front fields read zero on an empty queue
	assign front_tag = cnt_zero ? '0 : spq_pkg::TAG_W'(rd_q[TAG_BITS-1:0]);
	assign front_pri = cnt_zero ? '0 : rd_q[ENT_W-1 -: PRI_W];

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q <= {cnt_zero, spq_pkg::OCC_W'(cnt_q), front_pri, front_tag,
				spq_pkg::TAG_W'(removed_q), status_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = out_q;

endmodule

// ===== sv/spq_checker.sv =====
// Port-level checks for the sorted priority queue, bound to the top level.
// Depends on spq_pkg (result layout and codes).
module spq_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [spq_pkg::M_TDATA_W-1:0] m_tdata
);

	logic                          empty_b;
	logic [spq_pkg::OCC_W-1:0]     occ_b;
	logic [spq_pkg::STATUS_W-1:0]  status_b;
	logic [spq_pkg::TAG_W+spq_pkg::PRI_W-1:0] front_b;

	assign empty_b  = m_tdata[spq_pkg::O_EMPTY];
	assign occ_b    = m_tdata[spq_pkg::O_OCC +: spq_pkg::OCC_W];
	assign status_b = m_tdata[spq_pkg::O_STATUS +: spq_pkg::STATUS_W];
	assign front_b  = m_tdata[spq_pkg::O_FTAG +: spq_pkg::TAG_W + spq_pkg::PRI_W];

	// a stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat dropped or changed while stalled");

	// one input beat in flight: no accept right after an accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while previous item still in work");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (empty_b == (occ_b == '0)))
		else $error("is_empty disagrees with occupancy");

	a_empty_front: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && empty_b |-> front_b == '0 && status_b != spq_pkg::ST_FULL)
		else $error("empty queue reports a front entry or full status");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> status_b != spq_pkg::ST_BAD)
		else $error("undefined status code");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
